[sv/mln_pkg.sv]
`default_nettype none

package mln_pkg;

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int OBS_W   = 2;
   localparam int DATA_W  = 32;
   localparam int DELAY_W = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // number of page counters in one sample
   localparam int NUM_TYPES = 3;

   // default for the top level parameter
   localparam int DEF_NUM_OBSERVERS = 4;

   // fallbacks for zero configuration values
   localparam logic [DELAY_W-1:0] FALLBACK_BASE  = DELAY_W'(25);
   localparam logic [DATA_W-1:0]  FALLBACK_SPACE = DATA_W'(1024 >> 3);

   // register reset values
   localparam logic [DELAY_W-1:0] RESET_BASE  = DELAY_W'(25);
   localparam logic [DELAY_W-1:0] RESET_MAX   = DELAY_W'(1500);
   localparam logic [DATA_W-1:0]  RESET_SPACE = DATA_W'(128);

   typedef logic [NUM_TYPES-1:0][DATA_W-1:0] sample_type;
   typedef logic [NUM_TYPES-1:0]             mask_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE  = 3'd0,
      CMD_RECLAIM = 3'd1,
      CMD_OPEN    = 3'd2,
      CMD_SET     = 3'd3,
      CMD_POLL    = 3'd4,
      CMD_CLOSE   = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_PERIOD  = 2'd0,
      CSR_MAX_PERIOD   = 2'd1,
      CSR_CHANGE_SPACE = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_WALK
   } mln_state_type;

   // bit i set when threshold i is tracked and the current count reached it
   function automatic mask_type build_mask(input sample_type thr, input sample_type cur);
      mask_type m;
      m = '0;
      for (int i = 0; i < NUM_TYPES; i++) begin
         m[i] = (thr[i] != '0) && (cur[i] != '0) && (cur[i] >= thr[i]);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

[sv/memory_level_notifier.sv]
// a transaction is registered on acceptance and answered from the evaluation state; a sample that
//   changes the notified level walks the observer slots, one slot per cycle through the
//   threshold memory read port, and is answered when the walk stops
// throughput: one transaction in flight; the next is accepted once the answer is registered
// reset: synchronous, active high; registers return to their defaults, the period to the
//   base period, all slots closed with empty thresholds, first sample only primes
`default_nettype none

module memory_level_notifier #(
   parameter int NUM_OBSERVERS = mln_pkg::DEF_NUM_OBSERVERS
) (
   input  wire                               clock,
   input  wire                               reset,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [mln_pkg::CMD_W-1:0]         req_cmd,
   input  wire  [mln_pkg::OBS_W-1:0]         req_observer,
   input  wire  [mln_pkg::DATA_W-1:0]        req_used_value,
   input  wire  [mln_pkg::DATA_W-1:0]        req_active_value,
   input  wire  [mln_pkg::DATA_W-1:0]        req_total_value,
   // response channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [mln_pkg::DELAY_W-1:0]       rsp_next_delay,
   output logic                              rsp_rearm,
   output logic                              rsp_wake,
   output logic                              rsp_ready_res,
   output logic [mln_pkg::NUM_TYPES-1:0]     rsp_active_mask,
   // register write channel
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [mln_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [mln_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mln_pkg::*;

   localparam int SLOT_W = (NUM_OBSERVERS > 1) ? $clog2(NUM_OBSERVERS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_OBSERVERS - 1);

   // control state
   mln_state_type state_ff, state_in;

   // the transaction being worked on
   cmd_type           cmd_ff, cmd_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              obs_ok_ff, obs_ok_in;
   sample_type        val_ff, val_in;

   // walk pointer, also the read address source of the threshold memory
   logic [SLOT_W-1:0] walk_idx_ff, walk_idx_in;

   // configuration registers
   logic [DELAY_W-1:0] base_ff, base_in;
   logic [DELAY_W-1:0] max_ff, max_in;
   logic [DATA_W-1:0]  space_ff, space_in;

   // level tracking state
   sample_type         meas_ff, meas_in;
   sample_type         note_ff, note_in;
   logic               primed_ff, primed_in;
   logic [DELAY_W-1:0] period_ff, period_in;

   // per slot state; row_vld marks a threshold row written since open
   mask_type                 mask_ff [NUM_OBSERVERS];
   mask_type                 mask_in [NUM_OBSERVERS];
   logic [NUM_OBSERVERS-1:0] pend_ff, pend_in;
   logic [NUM_OBSERVERS-1:0] open_ff, open_in;
   logic [NUM_OBSERVERS-1:0] row_vld_ff, row_vld_in;

   // threshold memory, one row of all counters per slot
   sample_type        thr_mem [NUM_OBSERVERS];
   sample_type        rd_data_ff;
   logic              wr_en;
   logic [SLOT_W-1:0] wr_addr;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DELAY_W-1:0] rsp_delay_ff, rsp_delay_in;
   logic               rsp_rearm_ff, rsp_rearm_in;
   logic               rsp_wake_ff, rsp_wake_in;
   logic               rsp_ready_ff, rsp_ready_in;
   mask_type           rsp_mask_ff, rsp_mask_in;

   // shared decode
   logic [DELAY_W-1:0] eff_base;
   logic [DELAY_W-1:0] eff_max;
   logic [DATA_W-1:0]  eff_space;
   logic               level_change;
   logic               out_free;
   sample_type         cur_thr;
   mask_type           cur_mask;
   logic               walk_hit;
   logic               walk_done;
   logic               eval_walk;
   logic [DELAY_W:0]   period_dbl;

   assign eff_base  = (base_ff == '0) ? FALLBACK_BASE : base_ff;
   assign eff_max   = (max_ff < eff_base) ? eff_base : max_ff;
   assign eff_space = (space_ff == '0) ? FALLBACK_SPACE : space_ff;

   // dead band compare of the new sample against the last notified one;
   // a zero count on either side is untracked
   always_comb begin
      logic [DATA_W-1:0] diff;
      level_change = 1'b0;
      for (int i = 0; i < NUM_TYPES; i++) begin
         diff = (val_ff[i] >= note_ff[i]) ? (val_ff[i] - note_ff[i])
                                          : (note_ff[i] - val_ff[i]);
         if ((val_ff[i] != '0) && (note_ff[i] != '0) && (diff >= eff_space)) begin
            level_change = 1'b1;
         end
      end
   end

   // a finished answer may be registered when the response slot drains
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // row at walk_idx_ff, read in the cycle before; unwritten rows read as zero
   assign cur_thr  = row_vld_ff[walk_idx_ff] ? rd_data_ff : '0;
   assign cur_mask = build_mask(cur_thr, meas_ff);

   // slot becomes or already is pending: walk stops here
   assign walk_hit  = open_ff[walk_idx_ff] &&
                      ((cur_mask != mask_ff[walk_idx_ff]) || pend_ff[walk_idx_ff]);
   assign walk_done = walk_hit || (walk_idx_ff == LAST_SLOT);

   assign eval_walk = (cmd_ff == CMD_SAMPLE) && primed_ff && level_change;

   assign period_dbl = {period_ff, 1'b0};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_walk) begin
               state_in = ST_WALK;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            if (walk_done && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and response
   always_comb begin
      logic     produce;
      logic     r_rearm;
      logic     r_wake;
      logic     r_ready;
      mask_type r_mask;
      mask_type new_mask;

      produce  = 1'b0;
      r_rearm  = 1'b0;
      r_wake   = 1'b0;
      r_ready  = 1'b0;
      r_mask   = '0;
      new_mask = '0;

      cmd_in      = cmd_ff;
      slot_in     = slot_ff;
      obs_ok_in   = obs_ok_ff;
      val_in      = val_ff;
      walk_idx_in = walk_idx_ff;
      meas_in     = meas_ff;
      note_in     = note_ff;
      primed_in   = primed_ff;
      period_in   = period_ff;
      mask_in     = mask_ff;
      pend_in     = pend_ff;
      open_in     = open_ff;
      row_vld_in  = row_vld_ff;
      wr_en       = 1'b0;
      wr_addr     = slot_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_delay_in = rsp_delay_ff;
      rsp_rearm_in = rsp_rearm_ff;
      rsp_wake_in  = rsp_wake_ff;
      rsp_ready_in = rsp_ready_ff;
      rsp_mask_in  = rsp_mask_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = cmd_type'(req_cmd);
               slot_in     = SLOT_W'(req_observer);
               obs_ok_in   = 32'(req_observer) < NUM_OBSERVERS;
               val_in      = {req_total_value, req_active_value, req_used_value};
               // start the read of the addressed slot's thresholds
               walk_idx_in = SLOT_W'(req_observer);
            end
         end

         ST_EVAL: begin
            case (cmd_ff)
               CMD_SAMPLE: begin
                  if (eval_walk || out_free) begin
                     meas_in = val_ff;
                     r_rearm = 1'b1;
                     if (!primed_ff) begin
                        // first sample only primes the notified level
                        note_in   = val_ff;
                        period_in = eff_base;
                        primed_in = 1'b1;
                        produce   = 1'b1;
                     end else if (level_change) begin
                        // walk starts at slot zero, answer comes from the walk
                        note_in     = val_ff;
                        period_in   = eff_base;
                        walk_idx_in = '0;
                     end else begin
                        // quiet level: back off, doubled wide then clamped
                        period_in = (period_dbl > {1'b0, eff_max}) ? eff_max
                                                                   : period_dbl[DELAY_W-1:0];
                        produce   = 1'b1;
                     end
                  end
               end

               CMD_RECLAIM: begin
                  if (out_free) begin
                     if (period_ff != eff_base) begin
                        period_in = eff_base;
                        r_rearm   = 1'b1;
                     end
                     produce = 1'b1;
                  end
               end

               CMD_OPEN: begin
                  if (out_free) begin
                     if (obs_ok_ff && !open_ff[slot_ff]) begin
                        row_vld_in[slot_ff] = 1'b0;
                        mask_in[slot_ff]    = '0;
                        pend_in[slot_ff]    = 1'b0;
                        open_in[slot_ff]    = 1'b1;
                     end
                     produce = 1'b1;
                  end
               end

               CMD_SET: begin
                  if (out_free) begin
                     if (obs_ok_ff && open_ff[slot_ff]) begin
                        new_mask            = build_mask(val_ff, meas_ff);
                        wr_en               = 1'b1;
                        row_vld_in[slot_ff] = 1'b1;
                        pend_in[slot_ff]    = 1'b0;
                        mask_in[slot_ff]    = new_mask;
                        r_mask              = new_mask;
                     end
                     produce = 1'b1;
                  end
               end

               CMD_POLL: begin
                  if (out_free) begin
                     if (obs_ok_ff && open_ff[slot_ff]) begin
                        // walk_idx_ff holds the polled slot here
                        r_ready          = (cur_mask != mask_ff[slot_ff]) || pend_ff[slot_ff];
                        mask_in[slot_ff] = cur_mask;
                        pend_in[slot_ff] = 1'b0;
                        r_mask           = cur_mask;
                     end
                     produce = 1'b1;
                  end
               end

               CMD_CLOSE: begin
                  if (out_free) begin
                     if (obs_ok_ff && open_ff[slot_ff]) begin
                        row_vld_in[slot_ff] = 1'b0;
                        mask_in[slot_ff]    = '0;
                        pend_in[slot_ff]    = 1'b0;
                        open_in[slot_ff]    = 1'b0;
                     end
                     produce = 1'b1;
                  end
               end

               default: begin
                  // unknown command: report the period only
                  if (out_free) begin
                     produce = 1'b1;
                  end
               end
            endcase
         end

         ST_WALK: begin
            if (!walk_done) begin
               // nothing changes in a slot that is passed over
               walk_idx_in = walk_idx_ff + SLOT_W'(1);
            end else if (out_free) begin
               if (open_ff[walk_idx_ff] && (cur_mask != mask_ff[walk_idx_ff])) begin
                  mask_in[walk_idx_ff] = cur_mask;
                  pend_in[walk_idx_ff] = 1'b1;
               end
               r_rearm = 1'b1;
               r_wake  = walk_hit;
               produce = 1'b1;
            end
         end

         default: begin
         end
      endcase

      if (produce) begin
         rsp_valid_in = 1'b1;
         rsp_delay_in = period_in;
         rsp_rearm_in = r_rearm;
         rsp_wake_in  = r_wake;
         rsp_ready_in = r_ready;
         rsp_mask_in  = r_mask;
      end
   end

   // register writes, always accepted
   always_comb begin
      base_in  = base_ff;
      max_in   = max_ff;
      space_in = space_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_BASE_PERIOD:  base_in  = csr_wdata[DELAY_W-1:0];
            CSR_MAX_PERIOD:   max_in   = csr_wdata[DELAY_W-1:0];
            CSR_CHANGE_SPACE: space_in = csr_wdata[DATA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // threshold memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         thr_mem[wr_addr] <= val_ff;
      end
      rd_data_ff <= thr_mem[walk_idx_in];
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= RESET_BASE;
         max_ff       <= RESET_MAX;
         space_ff     <= RESET_SPACE;
         meas_ff      <= '0;
         note_ff      <= '0;
         primed_ff    <= 1'b0;
         period_ff    <= RESET_BASE;
         for (int i = 0; i < NUM_OBSERVERS; i++) begin
            mask_ff[i] <= '0;
         end
         pend_ff      <= '0;
         open_ff      <= '0;
         row_vld_ff   <= '0;
         walk_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         max_ff       <= max_in;
         space_ff     <= space_in;
         meas_ff      <= meas_in;
         note_ff      <= note_in;
         primed_ff    <= primed_in;
         period_ff    <= period_in;
         mask_ff      <= mask_in;
         pend_ff      <= pend_in;
         open_ff      <= open_in;
         row_vld_ff   <= row_vld_in;
         walk_idx_ff  <= walk_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // transaction payload and response fields
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      slot_ff      <= slot_in;
      obs_ok_ff    <= obs_ok_in;
      val_ff       <= val_in;
      rsp_delay_ff <= rsp_delay_in;
      rsp_rearm_ff <= rsp_rearm_in;
      rsp_wake_ff  <= rsp_wake_in;
      rsp_ready_ff <= rsp_ready_in;
      rsp_mask_ff  <= rsp_mask_in;
   end

   // ports
   assign req_stall       = (state_ff != ST_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_delay  = rsp_delay_ff;
   assign rsp_rearm       = rsp_rearm_ff;
   assign rsp_wake        = rsp_wake_ff;
   assign rsp_ready_res   = rsp_ready_ff;
   assign rsp_active_mask = rsp_mask_ff;

endmodule

`default_nettype wire

[sv/mln_checker.sv]
`default_nettype none

module mln_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_stall,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire  [mln_pkg::DELAY_W-1:0]       rsp_next_delay,
   input wire                               rsp_rearm,
   input wire                               rsp_wake,
   input wire                               rsp_ready_res,
   input wire  [mln_pkg::NUM_TYPES-1:0]     rsp_active_mask
);

   // reset empties the response slot
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one transaction in flight: busy right after an acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while a transaction is in flight");

   // a wake comes only from a sample, which always rearms and never polls
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_wake) |-> (rsp_rearm && !rsp_ready_res))
      else $error("wake without rearm or with poll result");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_next_delay)
                                    && $stable(rsp_active_mask)))
      else $error("stalled response changed");

endmodule

bind memory_level_notifier mln_checker u_mln_checker (.*);

`default_nettype wire
